// ===== src/assert_macros.svh =====
// Assertion helpers shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, masked while reset is high.
`define HGP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Checked property, also checked during reset.
`define HGP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error(msg);

`endif

// ===== src/hgp_pkg.sv =====
// ----------------------------------------------------------------------------
// hgp_pkg
// Types, constants and helpers for the HTTP GET request parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hgp_pkg;

   localparam int LEN_BITS  = 12;
   localparam int LIMIT_W   = 12;
   localparam int CSR_IDX_W = 4;
   localparam int CMP_W     = (LEN_BITS > LIMIT_W) ? LEN_BITS : LIMIT_W;

   localparam logic [LEN_BITS-1:0] POS_MAX = {LEN_BITS{1'b1}};
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(255);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATH_LIMIT  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_LIMIT = CSR_IDX_W'(1);

   // character constants
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [7:0] METHOD_TEXT  [4] = '{8'h47, 8'h45, 8'h54, 8'h20};
   localparam logic [7:0] VERSION_TEXT [7] =
      '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E};

   localparam int METHOD_LAST  = 3;
   localparam int VER_TEXT_LEN = 7;
   localparam int VER_CR_POS   = 8;

   typedef enum logic [2:0] {
      PH_METHOD   = 3'd0,
      PH_PATH     = 3'd1,
      PH_VERSION  = 3'd2,
      PH_NAME     = 3'd3,
      PH_COLON_SP = 3'd4,
      PH_VALUE    = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN  = 2'd0,
      ST_DONE = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_PATH  = 2'd1,
      KIND_NAME  = 2'd2,
      KIND_VALUE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      EV_NONE = 2'd0,
      EV_BYTE = 2'd1,
      EV_END  = 2'd2
   } event_type;

   typedef struct packed {
      phase_type             phase;
      logic [LEN_BITS-1:0]   position;
      logic                  cr_pending;
      status_type            status;
      logic [7:0]            header_count;
      logic [3:0]            version_digit;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:         PH_METHOD,
      position:      '0,
      cr_pending:    1'b0,
      status:        ST_RUN,
      header_count:  8'd0,
      version_digit: 4'd0
   };

   typedef struct packed {
      kind_type   token_kind;
      event_type  token_event;
      logic [7:0] data_byte;
      logic [7:0] header_index;
      logic [3:0] minor_version;
      status_type status;
   } result_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] path_limit;
      logic [LIMIT_W-1:0] field_limit;
   } limits_type;

   // clamp a limit to what the position counter can hold
   function automatic logic [LEN_BITS-1:0] eff_limit(input logic [LIMIT_W-1:0] lim);
      logic [CMP_W-1:0] lim_ext;
      logic [CMP_W-1:0] max_ext;
      lim_ext = CMP_W'(lim);
      max_ext = CMP_W'(POS_MAX);
      return (lim_ext > max_ext) ? LEN_BITS'(max_ext) : LEN_BITS'(lim_ext);
   endfunction

endpackage

`default_nettype wire

// ===== src/hgp_if.sv =====
// ----------------------------------------------------------------------------
// hgp_if
// Valid/ready channel interfaces for request, result and register words.
// ----------------------------------------------------------------------------
`default_nettype none

interface hgp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] byte_in;
   modport source (output valid, output action, output byte_in, input ready);
   modport sink   (input valid, input action, input byte_in, output ready);
endinterface

interface hgp_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] token_kind;
   logic [1:0] token_event;
   logic [7:0] data_byte;
   logic [7:0] header_index;
   logic [3:0] minor_version;
   logic [1:0] status;
   modport source (output valid, output token_kind, output token_event,
                   output data_byte, output header_index, output minor_version,
                   output status, input ready);
   modport sink   (input valid, input token_kind, input token_event,
                   input data_byte, input header_index, input minor_version,
                   input status, output ready);
endinterface

interface hgp_csr_if import hgp_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [LIMIT_W-1:0]   data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/hgp_csr.sv =====
// ----------------------------------------------------------------------------
// hgp_csr
// Limit registers written through the register channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hgp_csr import hgp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   hgp_csr_if.sink     csr_bus,
   output limits_type  limits
);

   limits_type limits_ff;
   limits_type limits_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      limits_in = limits_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_PATH_LIMIT:  limits_in.path_limit  = csr_bus.data;
            CSR_FIELD_LIMIT: limits_in.field_limit = csr_bus.data;
            default:         limits_in = limits_ff;   // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.path_limit  <= LIMIT_RESET;
         limits_ff.field_limit <= LIMIT_RESET;
      end else begin
         limits_ff <= limits_in;
      end
   end

   assign limits = limits_ff;

endmodule

`default_nettype wire

// ===== src/hgp_step.sv =====
// ----------------------------------------------------------------------------
// hgp_step
// Next-state and result logic for one request word.
// ----------------------------------------------------------------------------
`default_nettype none

module hgp_step import hgp_pkg::*; (
   input  wire state_type  cur,
   input  wire limits_type limits,
   input  wire logic   action,
   input  wire logic [7:0] byte_in,
   output state_type   nxt,
   output result_type  res
);

   logic [LEN_BITS-1:0] path_lim;
   logic [LEN_BITS-1:0] field_lim;
   logic [LEN_BITS-1:0] pos_inc;
   kind_type            kind;
   event_type           ev;
   logic [7:0]          data;
   logic [7:0]          hidx;
   logic [7:0]          digit;

   assign path_lim  = eff_limit(limits.path_limit);
   assign field_lim = eff_limit(limits.field_limit);
   assign pos_inc   = cur.position + LEN_BITS'(1);
   assign digit     = byte_in - CH_ZERO;

   always_comb begin
      nxt  = cur;
      kind = KIND_NONE;
      ev   = EV_NONE;
      data = 8'd0;
      hidx = cur.header_count;

      if (action) begin
         nxt  = STATE_RESET;
         hidx = 8'd0;
      end else if (cur.status == ST_RUN) begin
         unique case (cur.phase)
            PH_METHOD: begin
               if (cur.position > LEN_BITS'(METHOD_LAST) ||
                   byte_in != METHOD_TEXT[cur.position[1:0]]) begin
                  nxt.status = ST_ERR;
               end else if (cur.position == LEN_BITS'(METHOD_LAST)) begin
                  nxt.phase    = PH_PATH;
                  nxt.position = '0;
               end else begin
                  nxt.position = pos_inc;
               end
            end
            PH_PATH: begin
               if (byte_in == CH_SP) begin
                  kind         = KIND_PATH;
                  ev           = EV_END;
                  nxt.phase    = PH_VERSION;
                  nxt.position = '0;
               end else if (cur.position >= path_lim) begin
                  nxt.status = ST_ERR;
               end else begin
                  nxt.position = pos_inc;
                  kind         = KIND_PATH;
                  ev           = EV_BYTE;
                  data         = byte_in;
               end
            end
            PH_VERSION: begin
               if (cur.position < LEN_BITS'(VER_TEXT_LEN)) begin
                  if (byte_in != VERSION_TEXT[cur.position[2:0]]) nxt.status = ST_ERR;
                  else nxt.position = pos_inc;
               end else if (cur.position == LEN_BITS'(VER_TEXT_LEN)) begin
                  if (byte_in < CH_ZERO || byte_in > CH_NINE) begin
                     nxt.status = ST_ERR;
                  end else begin
                     nxt.version_digit = digit[3:0];
                     nxt.position      = pos_inc;
                  end
               end else if (cur.position == LEN_BITS'(VER_CR_POS)) begin
                  if (byte_in != CH_CR) nxt.status = ST_ERR;
                  else nxt.position = pos_inc;
               end else begin
                  if (byte_in != CH_LF) begin
                     nxt.status = ST_ERR;
                  end else begin
                     nxt.phase    = PH_NAME;
                     nxt.position = '0;
                  end
               end
            end
            PH_NAME: begin
               if (cur.cr_pending) begin
                  nxt.cr_pending = 1'b0;
                  nxt.status     = (byte_in == CH_LF) ? ST_DONE : ST_ERR;
               end else if (cur.position == '0 && byte_in == CH_CR) begin
                  nxt.cr_pending = 1'b1;
               end else if (byte_in == CH_COLON) begin
                  kind         = KIND_NAME;
                  ev           = EV_END;
                  nxt.phase    = PH_COLON_SP;
                  nxt.position = '0;
               end else if (cur.position >= field_lim) begin
                  nxt.status = ST_ERR;
               end else begin
                  nxt.position = pos_inc;
                  kind         = KIND_NAME;
                  ev           = EV_BYTE;
                  data         = byte_in;
               end
            end
            PH_COLON_SP: begin
               if (byte_in != CH_SP) begin
                  nxt.status = ST_ERR;
               end else begin
                  nxt.phase    = PH_VALUE;
                  nxt.position = '0;
               end
            end
            PH_VALUE: begin
               if (cur.cr_pending) begin
                  nxt.cr_pending = 1'b0;
                  if (byte_in != CH_LF) begin
                     nxt.status = ST_ERR;
                  end else begin
                     kind = KIND_VALUE;
                     ev   = EV_END;
                     if (cur.header_count != 8'hFF) begin
                        nxt.header_count = cur.header_count + 8'd1;
                     end
                     nxt.phase    = PH_NAME;
                     nxt.position = '0;
                  end
               end else if (byte_in == CH_CR) begin
                  nxt.cr_pending = 1'b1;
               end else if (cur.position >= field_lim) begin
                  nxt.status = ST_ERR;
               end else begin
                  nxt.position = pos_inc;
                  kind         = KIND_VALUE;
                  ev           = EV_BYTE;
                  data         = byte_in;
               end
            end
            default: nxt.status = ST_ERR;
         endcase
      end

      // a finished or failed request shows no token activity
      if (nxt.status != ST_RUN) begin
         kind = KIND_NONE;
         ev   = EV_NONE;
         data = 8'd0;
      end

      res.token_kind    = kind;
      res.token_event   = ev;
      res.data_byte     = data;
      res.header_index  = hidx;
      res.minor_version = nxt.version_digit;
      res.status        = nxt.status;
   end

endmodule

`default_nettype wire

// ===== src/http_get_request_parser_top.sv =====
// ----------------------------------------------------------------------------
// http_get_request_parser_top
// Byte-wise HTTP/1.x GET request line and header parser.
// ----------------------------------------------------------------------------
//
//   channel   direction  word contents
//   -------   ---------  ---------------------------------------------------
//   req_bus   in         action, byte_in
//   rsp_bus   out        token_kind, token_event, data_byte, header_index,
//                        minor_version, status
//   csr_bus   in         index, data (path_limit = 0, field_limit = 1)
//
// One request word per cycle sustained while the receiver takes every result;
// each request word goes into the input register, then through the step
// logic into the result register, which also carries the parser state
// update.
// Reset is synchronous: limits return to 255 and the parser to method match.
// A stalled result holds the result register; the input register keeps
// taking a word in the same cycle the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module http_get_request_parser_top import hgp_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   hgp_req_if.sink     req_bus,
   hgp_rsp_if.source   rsp_bus,
   hgp_csr_if.sink     csr_bus
);

   limits_type limits;

   // input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   // parser state
   state_type  state_ff;
   state_type  state_in;

   // result register
   logic       out_valid_ff;
   result_type out_res_ff;
   result_type out_res_in;

   logic advance;
   logic req_take;

   hgp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .limits  (limits)
   );

   hgp_step u_step (
      .cur     (state_ff),
      .limits  (limits),
      .action  (in_action_ff),
      .byte_in (in_byte_ff),
      .nxt     (state_in),
      .res     (out_res_in)
   );

   // advance the held word when the result register is free or draining
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_take       = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_bus.ready) in_valid_ff <= req_bus.valid;
         if (advance) begin
            state_ff     <= state_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_bus.action;
         in_byte_ff   <= req_bus.byte_in;
      end
      if (advance) out_res_ff <= out_res_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.token_kind    = out_res_ff.token_kind;
   assign rsp_bus.token_event   = out_res_ff.token_event;
   assign rsp_bus.data_byte     = out_res_ff.data_byte;
   assign rsp_bus.header_index  = out_res_ff.header_index;
   assign rsp_bus.minor_version = out_res_ff.minor_version;
   assign rsp_bus.status        = out_res_ff.status;

   `HGP_ASSERT(a_advance_fills, clock, reset,
      advance |=> out_valid_ff, "advance lost a result")
   `HGP_ASSERT(a_token_only_running, clock, reset,
      (out_valid_ff && out_res_ff.token_event != EV_NONE) |-> (out_res_ff.status == ST_RUN),
      "token activity on a finished request")
   `HGP_ASSERT(a_data_only_on_byte, clock, reset,
      (out_valid_ff && out_res_ff.token_event != EV_BYTE) |-> (out_res_ff.data_byte == 8'd0),
      "data byte without byte event")
   `HGP_ASSERT(a_sticky_hold, clock, reset,
      (advance && !in_action_ff && state_ff.status != ST_RUN) |=> $stable(state_ff),
      "state moved after finish")
   `HGP_ASSERT(a_restart_clears, clock, reset,
      (advance && in_action_ff) |=> (state_ff == STATE_RESET),
      "new request did not clear state")

endmodule

`default_nettype wire

// ===== bench/tb_http_get_request_parser_top.sv =====
// ----------------------------------------------------------------------------
// tb_http_get_request_parser_top
// Self-checking bench for the byte-wise HTTP GET request parser.
// ----------------------------------------------------------------------------
// Feeds request words (start or byte) through the req channel and reprograms
// the path and field limits between phases through the csr channel. A
// scoreboard class tracks the parse state, predicts one result word per
// accepted request word and checks each result word in order, one field at
// a time. A short directed part covers limit overflow, lone CR, the empty
// name and bytes after an error. The random part then sends mostly
// well-formed requests with random content, some of them corrupted or cut
// short, mixed with noise words. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_http_get_request_parser_top import hgp_pkg::*; ;

   // index that maps to no register; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_IDX_W'(9);
   localparam logic [LIMIT_W-1:0]   LIMIT_MAX  = {LIMIT_W{1'b1}};

   localparam int WORD_TARGET   = 1700; // request words sent in the whole run
   localparam int PHASE_WORDS   = 100;  // request words per limit setting
   localparam int SAT_HEADERS   = 258;  // enough headers to saturate the index

   // -------------------------------------------------------------------------
   // Scoreboard: parse state, limits and the queue of expected result words
   // -------------------------------------------------------------------------
   class token_scoreboard;
      phase_type           ph;
      logic [LEN_BITS-1:0] pos;
      bit                  cr_wait;
      status_type          st;
      logic [7:0]          hdr_cnt;
      logic [3:0]          ver;
      logic [LIMIT_W-1:0]  path_lim;
      logic [LIMIT_W-1:0]  field_lim;
      result_type          expected_tokens[$];
      int                  failures;
      int                  results_checked;
      int                  parsed_words;
      int                  all_words;
      logic [7:0]          peak_index;

      function new();
         path_lim   = LIMIT_RESET;
         field_lim  = LIMIT_RESET;
         peak_index = '0;
         clear_parse();
      endfunction

      function void clear_parse();
         ph      = PH_METHOD;
         pos     = '0;
         cr_wait = 1'b0;
         st      = ST_RUN;
         hdr_cnt = '0;
         ver     = '0;
      endfunction

      function void write_limit(input logic [CSR_IDX_W-1:0] idx,
                                input logic [LIMIT_W-1:0] value);
         if (idx == CSR_PATH_LIMIT)
            path_lim = value;
         else if (idx == CSR_FIELD_LIMIT)
            field_lim = value;
      endfunction

      function int pending();
         return expected_tokens.size();
      endfunction

      // count one token byte, or flag error when the limit is reached
      function bit take_byte(input logic [LIMIT_W-1:0] lim);
         if (pos >= lim) begin
            st = ST_ERR;
            return 1'b0;
         end
         pos = pos + 1'b1;
         return 1'b1;
      endfunction

      // work out the result word for one accepted request word
      function void predict_word(input logic act, input logic [7:0] b);
         result_type r;
         r = '0;
         r.header_index = hdr_cnt;
         all_words++;
         if (act || st == ST_RUN)
            parsed_words++;
         if (act) begin
            clear_parse();
            r.header_index = '0;
         end else if (st == ST_RUN) begin
            case (ph)
               PH_METHOD: begin
                  if (b != METHOD_TEXT[pos[1:0]])
                     st = ST_ERR;
                  else if (pos == METHOD_LAST) begin
                     ph  = PH_PATH;
                     pos = '0;
                  end else
                     pos = pos + 1'b1;
               end
               PH_PATH: begin
                  if (b == CH_SP) begin
                     r.token_kind  = KIND_PATH;
                     r.token_event = EV_END;
                     ph  = PH_VERSION;
                     pos = '0;
                  end else if (take_byte(path_lim)) begin
                     r.token_kind  = KIND_PATH;
                     r.token_event = EV_BYTE;
                     r.data_byte   = b;
                  end
               end
               PH_VERSION: begin
                  if (pos < VER_TEXT_LEN) begin
                     if (b != VERSION_TEXT[pos[2:0]]) st = ST_ERR;
                     else pos = pos + 1'b1;
                  end else if (pos == VER_TEXT_LEN) begin
                     if (b < CH_ZERO || b > CH_NINE) st = ST_ERR;
                     else begin
                        ver = 4'(b - CH_ZERO);
                        pos = pos + 1'b1;
                     end
                  end else if (pos == VER_CR_POS) begin
                     if (b != CH_CR) st = ST_ERR;
                     else pos = pos + 1'b1;
                  end else begin
                     if (b != CH_LF) st = ST_ERR;
                     else begin
                        ph  = PH_NAME;
                        pos = '0;
                     end
                  end
               end
               PH_NAME: begin
                  if (cr_wait) begin
                     cr_wait = 1'b0;
                     st = (b == CH_LF) ? ST_DONE : ST_ERR;
                  end else if (pos == 0 && b == CH_CR) begin
                     cr_wait = 1'b1;
                  end else if (b == CH_COLON) begin
                     r.token_kind  = KIND_NAME;
                     r.token_event = EV_END;
                     ph  = PH_COLON_SP;
                     pos = '0;
                  end else if (take_byte(field_lim)) begin
                     r.token_kind  = KIND_NAME;
                     r.token_event = EV_BYTE;
                     r.data_byte   = b;
                  end
               end
               PH_COLON_SP: begin
                  if (b != CH_SP)
                     st = ST_ERR;
                  else begin
                     ph  = PH_VALUE;
                     pos = '0;
                  end
               end
               PH_VALUE: begin
                  if (cr_wait) begin
                     cr_wait = 1'b0;
                     if (b != CH_LF)
                        st = ST_ERR;
                     else begin
                        r.token_kind  = KIND_VALUE;
                        r.token_event = EV_END;
                        if (hdr_cnt != 8'd255) hdr_cnt = hdr_cnt + 1'b1;
                        ph  = PH_NAME;
                        pos = '0;
                     end
                  end else if (b == CH_CR) begin
                     cr_wait = 1'b1;
                  end else if (take_byte(field_lim)) begin
                     r.token_kind  = KIND_VALUE;
                     r.token_event = EV_BYTE;
                     r.data_byte   = b;
                  end
               end
               default: st = ST_ERR;
            endcase
            // the word that ends the parse carries no token activity
            if (st != ST_RUN) begin
               r.token_kind  = KIND_NONE;
               r.token_event = EV_NONE;
               r.data_byte   = '0;
            end
         end
         r.minor_version = ver;
         r.status        = st;
         expected_tokens.push_back(r);
      endfunction

      // compare one result word with the oldest expectation
      function void check_result(input logic [1:0] kind, input logic [1:0] ev,
                                 input logic [7:0] data, input logic [7:0] hidx,
                                 input logic [3:0] minor, input logic [1:0] stat);
         result_type want;
         results_checked++;
         if (expected_tokens.size() == 0) begin
            $error("result word %0d arrived with no request word waiting",
                   results_checked);
            failures++;
            return;
         end
         want = expected_tokens.pop_front();
         if (hidx > peak_index) peak_index = hidx;
         if (kind !== want.token_kind) begin
            $error("token_kind: expected %0d, got %0d (result %0d)",
                   want.token_kind, kind, results_checked);
            failures++;
         end
         if (ev !== want.token_event) begin
            $error("token_event: expected %0d, got %0d (result %0d)",
                   want.token_event, ev, results_checked);
            failures++;
         end
         if (data !== want.data_byte) begin
            $error("data_byte: expected %0d, got %0d (result %0d)",
                   want.data_byte, data, results_checked);
            failures++;
         end
         if (hidx !== want.header_index) begin
            $error("header_index: expected %0d, got %0d (result %0d)",
                   want.header_index, hidx, results_checked);
            failures++;
         end
         if (minor !== want.minor_version) begin
            $error("minor_version: expected %0d, got %0d (result %0d)",
                   want.minor_version, minor, results_checked);
            failures++;
         end
         if (stat !== want.status) begin
            $error("status: expected %0d, got %0d (result %0d)",
                   want.status, stat, results_checked);
            failures++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, channels and the block
   // -------------------------------------------------------------------------
   logic clock;
   logic reset;

   hgp_req_if req_bus ();
   hgp_rsp_if rsp_bus ();
   hgp_csr_if csr_bus ();

   http_get_request_parser_top i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   token_scoreboard token_sb = new();

   bit         req_gaps_on;   // sender may idle between words
   bit         rsp_stalls_on; // receiver may drop ready
   int         limit_writes;
   logic [7:0] request_text[$];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #16_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Random helpers
   // -------------------------------------------------------------------------

   // idle length: mostly short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 90) return $urandom_range(4, 8);
      return $urandom_range(12, 40);
   endfunction

   // token length: mostly short, some medium, a few long
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 4);
      if (r < 95) return $urandom_range(5, 16);
      return $urandom_range(17, 60);
   endfunction

   // random byte biased toward the delimiters, never one of the two avoided
   function automatic logic [7:0] pick_byte(input logic [7:0] avoid_a,
                                            input logic [7:0] avoid_b);
      logic [7:0] b;
      do begin
         if ($urandom_range(0, 99) < 15) begin
            case ($urandom_range(0, 5))
               0:       b = CH_CR;
               1:       b = CH_LF;
               2:       b = CH_SP;
               3:       b = CH_COLON;
               4:       b = 8'h00;
               default: b = 8'hFF;
            endcase
         end else
            b = 8'($urandom);
      end while (b == avoid_a || b == avoid_b);
      return b;
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         request_text.push_back(s[i]);
   endfunction

   function automatic void push_line_end();
      request_text.push_back(CH_CR);
      request_text.push_back(CH_LF);
   endfunction

   // Build one request: well-formed with random content, then maybe damaged.
   function automatic void build_request();
      int n;
      int n_hdr;
      int r;
      int at;
      request_text.delete();
      push_text("GET ");
      n = pick_len();
      repeat (n) request_text.push_back(pick_byte(CH_SP, CH_SP));
      push_text(" HTTP/1.");
      request_text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      push_line_end();
      n_hdr = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 3) : $urandom_range(4, 12);
      repeat (n_hdr) begin
         n = pick_len();
         // a CR opens the empty line only at the start of a name
         for (int i = 0; i < n; i++)
            request_text.push_back((i == 0) ? pick_byte(CH_COLON, CH_CR)
                                            : pick_byte(CH_COLON, CH_COLON));
         push_text(": ");
         n = pick_len();
         repeat (n) request_text.push_back(pick_byte(CH_CR, CH_CR));
         push_line_end();
      end
      push_line_end();
      // trailing junk after the empty line must be ignored
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) request_text.push_back(8'($urandom));

      r  = $urandom_range(0, 99);
      at = $urandom_range(0, request_text.size() - 1);
      if (r < 18) begin
         request_text[at] = 8'($urandom);
      end else if (r < 25) begin
         // break a CR LF pair to provoke a lone CR or a bad line end
         while (at < request_text.size() && request_text[at] != CH_LF) at++;
         if (at < request_text.size()) request_text[at] = pick_byte(CH_LF, CH_LF);
      end else if (r < 33) begin
         while (request_text.size() > at + 1) void'(request_text.pop_back());
      end
   endfunction

   // -------------------------------------------------------------------------
   // Channel drivers
   // -------------------------------------------------------------------------

   // Offer one request word and hold it until taken; valid stays high after.
   task automatic send_word(input logic act, input logic [7:0] b);
      int gap;
      gap = (req_gaps_on && $urandom_range(0, 99) < 35) ? gap_len() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.action  <= act;
      req_bus.byte_in <= b;
      do @(posedge clock); while (!req_bus.ready);
      token_sb.predict_word(act, b);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_word(1'b0, s[i]);
   endtask

   // start word, then the built request bytes
   task automatic send_request();
      send_word(1'b1, 8'($urandom));
      foreach (request_text[i])
         send_word(1'b0, request_text[i]);
   endtask

   // Drop valid and hold until every expected result word has come back.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (token_sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One register write; valid goes low again after it is taken.
   task automatic write_limit(input logic [CSR_IDX_W-1:0] idx,
                              input logic [LIMIT_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      token_sb.write_limit(idx, value);
      limit_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_limits(input logic [LIMIT_W-1:0] path_value,
                               input logic [LIMIT_W-1:0] field_value);
      settle();
      write_limit(CSR_PATH_LIMIT, path_value);
      write_limit(CSR_FIELD_LIMIT, field_value);
   endtask

   // -------------------------------------------------------------------------
   // Result side: check every taken word, stall at random
   // -------------------------------------------------------------------------
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            token_sb.check_result(rsp_bus.token_kind, rsp_bus.token_event,
                                  rsp_bus.data_byte, rsp_bus.header_index,
                                  rsp_bus.minor_version, rsp_bus.status);
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rsp_stalls_on && $urandom_range(0, 99) < 30)
               stall_left = gap_len();
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int phase_no;
      int phase_end;

      req_bus.valid   <= 1'b0;
      req_bus.action  <= 1'b0;
      req_bus.byte_in <= 8'h00;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= CSR_PATH_LIMIT;
      csr_bus.data    <= '0;
      reset           <= 1'b1;
      req_gaps_on      = 1'b1;
      rsp_stalls_on    = 1'b1;
      limit_writes     = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero limits, so any path byte overflows at once.
      write_limit(CSR_PATH_LIMIT, '0);
      write_limit(CSR_FIELD_LIMIT, '0);
      send_word(1'b1, 8'hFF);          // start ignores its byte
      send_text("GET ");
      send_word(1'b0, "x");            // path overflow sets error
      send_word(1'b0, 8'h00);          // ignored after error

      // Empty path, top digit, empty name, then a lone CR inside the value.
      send_word(1'b1, 8'h00);
      send_text("GET  HTTP/1.9");
      send_word(1'b0, CH_CR);
      send_word(1'b0, CH_LF);
      send_word(1'b0, CH_COLON);
      send_word(1'b0, CH_SP);
      send_word(1'b0, CH_CR);
      send_word(1'b0, CH_CR);

      // an unmapped index must leave both limits alone
      settle();
      write_limit(CSR_UNUSED, LIMIT_MAX);

      // Random part: one limit setting per phase, extremes included.
      phase_no = 0;
      while (token_sb.all_words < WORD_TARGET) begin
         case (phase_no % 6)
            0: apply_limits(LIMIT_MAX, LIMIT_MAX);
            1: apply_limits(LIMIT_W'($urandom_range(1, 8)),
                            LIMIT_W'($urandom_range(1, 8)));
            2: apply_limits('0, LIMIT_MAX);
            3: apply_limits(LIMIT_MAX, '0);
            4: apply_limits(LIMIT_RESET, LIMIT_RESET);
            default: apply_limits(LIMIT_W'($urandom_range(0, 4095)),
                                  LIMIT_W'($urandom_range(0, 4095)));
         endcase
         phase_end = token_sb.all_words + PHASE_WORDS;
         while (token_sb.all_words < phase_end && token_sb.all_words < WORD_TARGET) begin
            // stretches with no idling on either side now and then
            req_gaps_on   = ($urandom_range(0, 3) != 0);
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
               // noise: stray bytes and the odd start word
               repeat ($urandom_range(1, 8))
                  send_word($urandom_range(0, 9) == 0, 8'($urandom));
            end else begin
               build_request();
               send_request();
            end
            // hold the sender until the result side has fully drained
            if ($urandom_range(0, 19) == 0) settle();
         end

         // Once: enough minimal headers to drive the index into saturation.
         if (phase_no == 0) begin
            request_text.delete();
            push_text("GET  HTTP/1.1");
            push_line_end();
            repeat (SAT_HEADERS) begin
               push_text(": ");
               push_line_end();
            end
            push_line_end();
            send_request();
         end
         phase_no++;
      end

      // Drain and let the pipeline run dry before the verdict.
      settle();
      repeat (8) @(posedge clock);

      $display("Sent %0d request words (%0d parsed) over %0d limit phases;",
               token_sb.all_words, token_sb.parsed_words, phase_no);
      $display("%0d register writes, %0d result words checked, top header index %0d.",
               limit_writes, token_sb.results_checked, token_sb.peak_index);
      if (token_sb.failures == 0 && token_sb.pending() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

`default_nettype wire
